@@ design/cft_pkg.sv @@
`timescale 1ns / 1ps

package cft_pkg;

  // character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // field capacity after reset
  localparam logic [7:0] CAP_RESET = 8'd17;

  // entries in the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_PLAIN   = 3'd1,
    MODE_QUOTED  = 3'd2,
    MODE_PENDING = 3'd3,
    MODE_SKIP    = 3'd4
  } mode_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_done;
    logic [7:0] field_index;
    logic       line_done;
    logic [7:0] field_count;
  } result_t;

  // all results caused by one input byte, in order
  typedef struct packed {
    logic    first_valid;
    result_t first;
    logic    second_valid;
    result_t second;
  } entry_t;

  function automatic logic mode_is_open(mode_e mode);
    return (mode == MODE_PLAIN) || (mode == MODE_QUOTED) || (mode == MODE_PENDING);
  endfunction

endpackage

@@ design/cft_front.sv @@
`timescale 1ns / 1ps

module cft_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_line_i,
  input  logic            full_i,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_data_i,
  output logic            wr_en_o,
  output cft_pkg::entry_t wr_entry_o
);
  import cft_pkg::*;

  mode_e      mode_q, mode_d, mode_b;
  logic [7:0] seen_q, seen_d, seen_b;
  logic       term_q, term_d, term_b;
  logic [7:0] cap_q;

  logic       accept;
  logic       is_nul, is_quote, is_comma, is_crlf;
  logic       opens, plain_go, tail_close;
  logic [7:0] prev_idx, cur_idx;
  entry_t     entry;

  assign accept   = push_i && !full_i;
  assign is_nul   = (in_byte_i == CHAR_NUL);
  assign is_quote = (in_byte_i == CHAR_QUOTE);
  assign is_comma = (in_byte_i == CHAR_COMMA);
  assign is_crlf  = (in_byte_i == CHAR_CR) || (in_byte_i == CHAR_LF);

  // byte opens a new field from start or skip mode
  assign opens = !term_q && !is_nul && (seen_q < cap_q) &&
                 ((mode_q == MODE_START) || ((mode_q == MODE_SKIP) && !is_crlf));

  // byte goes through the unquoted rule
  assign plain_go = !term_q && !is_nul &&
                    ((opens && !is_quote) || (mode_q == MODE_PLAIN) ||
                     ((mode_q == MODE_PENDING) && !is_quote));

  assign prev_idx = seen_q - 8'd1;
  assign cur_idx  = opens ? seen_q : prev_idx;

  // next state
  always_comb begin
    mode_b = mode_q;
    seen_b = seen_q + {7'd0, opens};
    term_b = term_q;
    if (!term_q) begin
      if (is_nul) begin
        mode_b = MODE_START;
        term_b = 1'b1;
      end else if (plain_go) begin
        if (is_comma) begin
          mode_b = MODE_START;
        end else if (is_crlf) begin
          mode_b = MODE_SKIP;
        end else begin
          mode_b = MODE_PLAIN;
        end
      end else if (opens) begin
        mode_b = MODE_QUOTED;
      end else begin
        unique case (mode_q)
          MODE_START:   mode_b = MODE_START;
          MODE_SKIP:    mode_b = MODE_SKIP;
          MODE_PLAIN:   mode_b = MODE_PLAIN;
          MODE_QUOTED:  mode_b = is_quote ? MODE_PENDING : MODE_QUOTED;
          MODE_PENDING: mode_b = MODE_QUOTED;
          default:      mode_b = MODE_START;
        endcase
      end
    end
    if (end_of_line_i) begin
      mode_d = MODE_START;
      seen_d = 8'd0;
      term_d = 1'b0;
    end else begin
      mode_d = mode_b;
      seen_d = seen_b;
      term_d = term_b;
    end
  end

  // results of this byte
  assign tail_close = !term_b && mode_is_open(mode_b);

  always_comb begin
    entry = '0;
    if (!term_q) begin
      if (is_nul) begin
        if (mode_is_open(mode_q)) begin
          entry.first_valid            = 1'b1;
          entry.first.field_done       = 1'b1;
          entry.first.field_index      = prev_idx;
        end
      end else if (plain_go) begin
        entry.first_valid              = 1'b1;
        entry.first.field_index        = cur_idx;
        if (is_comma || is_crlf) begin
          entry.first.field_done       = 1'b1;
        end else begin
          entry.first.byte_valid       = 1'b1;
          entry.first.out_byte         = in_byte_i;
        end
      end else if (((mode_q == MODE_QUOTED) && !is_quote) ||
                   ((mode_q == MODE_PENDING) && is_quote)) begin
        entry.first_valid              = 1'b1;
        entry.first.byte_valid         = 1'b1;
        entry.first.out_byte           = in_byte_i;
        entry.first.field_index        = prev_idx;
      end
    end
    if (end_of_line_i) begin
      entry.second_valid = tail_close || !entry.first_valid;
      if (tail_close) begin
        entry.second.field_done  = 1'b1;
        entry.second.field_index = seen_b - 8'd1;
      end
      if (entry.second_valid) begin
        entry.second.line_done   = 1'b1;
        entry.second.field_count = seen_b;
      end else begin
        entry.first.line_done    = 1'b1;
        entry.first.field_count  = seen_b;
      end
    end
  end

  assign wr_en_o    = accept && (entry.first_valid || entry.second_valid);
  assign wr_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      seen_q <= 8'd0;
      term_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      seen_q <= seen_d;
      term_q <= term_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

endmodule

@@ design/cft_queue.sv @@
`timescale 1ns / 1ps

module cft_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  cft_pkg::entry_t wr_entry_i,
  input  logic            rd_en_i,
  output cft_pkg::entry_t rd_entry_o,
  output logic            rd_valid_o,
  output logic            full_o
);
  import cft_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && rd_valid_o;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_entry_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_wr) - CntW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slots_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

@@ design/cft_back.sv @@
`timescale 1ns / 1ps

module cft_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cft_pkg::entry_t  head_i,
  input  logic             head_valid_i,
  output logic             head_take_o,
  input  logic             pop_i,
  output logic             empty_o,
  output cft_pkg::result_t result_o
);
  import cft_pkg::*;

  // set once the first result of the head entry is gone
  logic sub_q, sub_d;
  logic show_first, last_slot, taken;

  assign show_first  = !sub_q && head_i.first_valid;
  // an entry holding a single result, in either slot, leaves on its first pop
  assign last_slot   = sub_q || !head_i.first_valid || !head_i.second_valid;
  assign empty_o     = !head_valid_i;
  assign taken       = pop_i && head_valid_i;
  assign head_take_o = taken && last_slot;
  assign result_o    = show_first ? head_i.first : head_i.second;

  always_comb begin
    sub_d = sub_q;
    if (taken) begin
      sub_d = !last_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule

@@ design/csv_field_tokenizer_top.sv @@
`timescale 1ns / 1ps

// channel   | handshake              | transfer when       | payload
// ----------+------------------------+---------------------+------------------------------
// input     | push_i / full_o        | push_i && !full_o   | in_byte_i, end_of_line_i
// result    | empty_o / pop_i        | pop_i && !empty_o   | out_byte_o .. field_count_o
// config    | cfg_we_i               | cfg_we_i            | cfg_data_i (field capacity)
//
// one byte is taken per cycle unless full; its results enter the queue in the same cycle
// the result side drains one result per cycle, so a byte with two results costs two pops
// full_o rises when the queue holds QueueDepth entries; the front stalls without losing state
// a byte with no result (opening quote, skipped CR/LF, bytes after a terminator) uses no entry
// reset clears parse state, queue pointers and sets field capacity to 17; no clearing pass

module csv_field_tokenizer_top #(
  parameter int unsigned QueueDepth = cft_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte input
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_line_i,
  // result output
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       field_done_o,
  output logic [7:0] field_index_o,
  output logic       line_done_o,
  output logic [7:0] field_count_o,
  // capacity register
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);
  import cft_pkg::*;

  // front to queue
  logic    wr_en;
  entry_t  wr_entry;
  logic    queue_full;
  // queue to back
  entry_t  head;
  logic    head_valid;
  logic    head_take;
  result_t result;

  // front: mode tracking, field counting, result building per byte
  cft_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .in_byte_i     (in_byte_i),
    .end_of_line_i (end_of_line_i),
    .full_i        (queue_full),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .wr_en_o       (wr_en),
    .wr_entry_o    (wr_entry)
  );

  // decoupling queue, one entry per byte that has results
  cft_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_entry_i (wr_entry),
    .rd_en_i    (head_take),
    .rd_entry_o (head),
    .rd_valid_o (head_valid),
    .full_o     (queue_full)
  );

  // back: hands out the one or two results of the head entry in order
  cft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .head_take_o  (head_take),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .result_o     (result)
  );

  assign full_o        = queue_full;
  assign out_byte_o    = result.out_byte;
  assign byte_valid_o  = result.byte_valid;
  assign field_done_o  = result.field_done;
  assign field_index_o = result.field_index;
  assign line_done_o   = result.line_done;
  assign field_count_o = result.field_count;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cft_pkg::*;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       push_i        = 1'b0;
  logic [7:0] in_byte_i     = 8'h00;
  logic       end_of_line_i = 1'b0;
  logic       pop_i         = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic [7:0] cfg_data_i    = 8'h00;

  logic       full_o;
  logic       empty_o;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       field_done_o;
  logic [7:0] field_index_o;
  logic       line_done_o;
  logic [7:0] field_count_o;

  always #5 clk_i = ~clk_i;

  csv_field_tokenizer_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .in_byte_i     (in_byte_i),
    .end_of_line_i (end_of_line_i),
    .empty_o       (empty_o),
    .pop_i         (pop_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .field_done_o  (field_done_o),
    .field_index_o (field_index_o),
    .line_done_o   (line_done_o),
    .field_count_o (field_count_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // tokenizer prediction: own copy of the line state and the capacity
  // ---------------------------------------------------------------------------
  logic [7:0] tk_cap  = CAP_RESET;
  mode_e      tk_mode = MODE_START;
  logic [7:0] tk_seen = 8'd0;
  logic       tk_term = 1'b0;

  result_t byte_tokens[$];   // tokens caused by the byte just transferred
  result_t token_q[$];       // tokens still to come out of the block, oldest first

  function automatic logic is_break(input logic [7:0] b);
    return (b == CHAR_CR) || (b == CHAR_LF);
  endfunction

  function automatic logic in_field(input mode_e m);
    return (m == MODE_PLAIN) || (m == MODE_QUOTED) || (m == MODE_PENDING);
  endfunction

  task automatic add_token(input logic [7:0] b, input logic bv, input logic fd,
                           input logic [7:0] idx);
    result_t r;
    r             = '0;
    r.out_byte    = b;
    r.byte_valid  = bv;
    r.field_done  = fd;
    r.field_index = idx;
    byte_tokens.push_back(r);
  endtask

  // byte seen outside quotes within an open field
  task automatic unquoted_byte(input logic [7:0] b);
    logic [7:0] idx;
    idx = tk_seen - 8'd1;
    if (b == CHAR_COMMA) begin
      add_token(8'h00, 1'b0, 1'b1, idx);
      tk_mode = MODE_START;
    end else if (is_break(b)) begin
      add_token(8'h00, 1'b0, 1'b1, idx);
      tk_mode = MODE_SKIP;
    end else begin
      add_token(b, 1'b1, 1'b0, idx);
    end
  endtask

  task automatic tokenize_byte(input logic [7:0] b, input logic eol);
    logic [7:0] idx;
    result_t    r;
    byte_tokens.delete();
    idx = tk_seen - 8'd1;
    if (!tk_term) begin
      if (b == CHAR_NUL) begin
        // terminator closes whatever field is open, rest of line ignored
        if (in_field(tk_mode)) add_token(8'h00, 1'b0, 1'b1, idx);
        tk_mode = MODE_START;
        tk_term = 1'b1;
      end else if (tk_mode == MODE_START || tk_mode == MODE_SKIP) begin
        // line breaks after a break are skipped, otherwise open a field if room
        if (!(tk_mode == MODE_SKIP && is_break(b)) && tk_seen < tk_cap) begin
          tk_seen = tk_seen + 8'd1;
          if (b == CHAR_QUOTE) begin
            tk_mode = MODE_QUOTED;
          end else begin
            tk_mode = MODE_PLAIN;
            unquoted_byte(b);
          end
        end
      end else if (tk_mode == MODE_PLAIN) begin
        unquoted_byte(b);
      end else if (tk_mode == MODE_QUOTED) begin
        if (b == CHAR_QUOTE) tk_mode = MODE_PENDING;
        else add_token(b, 1'b1, 1'b0, idx);
      end else if (tk_mode == MODE_PENDING) begin
        // doubled quote gives one quote, anything else leaves quoted mode
        if (b == CHAR_QUOTE) begin
          add_token(b, 1'b1, 1'b0, idx);
          tk_mode = MODE_QUOTED;
        end else begin
          tk_mode = MODE_PLAIN;
          unquoted_byte(b);
        end
      end
    end
    if (eol) begin
      idx = tk_seen - 8'd1;
      if (!tk_term && in_field(tk_mode)) add_token(8'h00, 1'b0, 1'b1, idx);
      else if (byte_tokens.size() == 0) add_token(8'h00, 1'b0, 1'b0, 8'h00);
      // last token of the line carries the count
      r             = byte_tokens.pop_back();
      r.line_done   = 1'b1;
      r.field_count = tk_seen;
      byte_tokens.push_back(r);
      tk_mode = MODE_START;
      tk_seen = 8'd0;
      tk_term = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: checking every transfer against the oldest expected token
  // ---------------------------------------------------------------------------
  int n_err     = 0;
  int n_checked = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    n_err++;
    $display("%0t ns: token %0d %s: got %0d, want %0d", $time, n_checked, what, got, want);
  endtask

  always @(posedge clk_i) begin
    result_t w;
    if (rst_ni && pop_i && !empty_o) begin
      if (token_q.size() == 0) begin
        report_mismatch("arrived with none expected, out_byte", out_byte_o, 0);
      end else begin
        w = token_q.pop_front();
        if (out_byte_o != w.out_byte)
          report_mismatch("out_byte", out_byte_o, w.out_byte);
        if (byte_valid_o != w.byte_valid)
          report_mismatch("byte_valid", byte_valid_o, w.byte_valid);
        if (field_done_o != w.field_done)
          report_mismatch("field_done", field_done_o, w.field_done);
        if (field_index_o != w.field_index)
          report_mismatch("field_index", field_index_o, w.field_index);
        if (line_done_o != w.line_done)
          report_mismatch("line_done", line_done_o, w.line_done);
        if (field_count_o != w.field_count)
          report_mismatch("field_count", field_count_o, w.field_count);
      end
      n_checked++;
    end
  end

  // receiver: stalls in stretches of its own pattern, plus a long hold-off on request
  logic hold_req = 1'b0;

  initial begin
    int          rx_mode;
    int          rx_left;
    logic [15:0] pat;
    rx_mode = 0;
    rx_left = 0;
    pat     = 16'b1101_1110_0110_1011;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // long hold-off so the queue fills and full_o backs up the sender
        hold_req = 1'b0;
        pop_i <= 1'b0;
        repeat (200) @(posedge clk_i);
      end else begin
        if (rx_left == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        pat = {pat[14:0], pat[15]};
        case (rx_mode)
          0: pop_i <= 1'b1;
          1: pop_i <= pat[0];
          2: pop_i <= 1'($urandom_range(0, 1));
          default: pop_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // offer one byte and hold it until the transfer; a typed row replaces the prediction
  task automatic send_byte(input logic [7:0] b, input logic eol, input logic typed,
                           input result_t want);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    push_i        <= 1'b1;
    in_byte_i     <= b;
    end_of_line_i <= eol;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    tokenize_byte(b, eol);
    if (typed) token_q.push_back(want);
    else foreach (byte_tokens[i]) token_q.push_back(byte_tokens[i]);
    burst_left--;
  endtask

  // sender pauses until every expected token is out
  task automatic drain();
    push_i <= 1'b0;
    burst_left = 0;
    while (token_q.size() != 0) @(posedge clk_i);
  endtask

  // capacity is changed only with the block idle
  task automatic set_capacity(input logic [7:0] cap);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tk_cap = cap;
  endtask

  // directed table: byte, end of line, and where obvious the one token it gives
  typedef struct {
    logic [7:0] b;
    logic       eol;
    logic       typed;
    result_t    want;
  } row_t;

  row_t dir_tab[$];

  task automatic row(input logic [7:0] b, input logic eol);
    row_t r;
    r.b     = b;
    r.eol   = eol;
    r.typed = 1'b0;
    r.want  = '0;
    dir_tab.push_back(r);
  endtask

  task automatic row_typed(input logic [7:0] b, input logic eol, input logic [7:0] wb,
                           input logic wbv, input logic wfd, input logic [7:0] widx,
                           input logic wld, input logic [7:0] wcnt);
    row_t r;
    r.b     = b;
    r.eol   = eol;
    r.typed = 1'b1;
    r.want  = '{out_byte: wb, byte_valid: wbv, field_done: wfd, field_index: widx,
                line_done: wld, field_count: wcnt};
    dir_tab.push_back(r);
  endtask

  // random stimulus: mostly well-formed lines, some noise and broken quoting
  logic [7:0] line_q[$];

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (c == CHAR_COMMA || c == CHAR_QUOTE || is_break(c)) c = 8'h41 + 8'($urandom_range(0, 25));
    return c;
  endfunction

  task automatic add_field();
    int kind;
    int len;
    kind = $urandom_range(0, 3);
    len  = $urandom_range(1, 6);
    if (kind == 0) begin
      // empty field, nothing to add
    end else if (kind < 3) begin
      for (int j = 0; j < len; j++) begin
        // a stray quote inside an unquoted field is plain content
        if (j > 0 && $urandom_range(0, 9) == 0) line_q.push_back(CHAR_QUOTE);
        else line_q.push_back(text_char());
      end
    end else begin
      line_q.push_back(CHAR_QUOTE);
      len = $urandom_range(0, 6);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(0, 7))
          0: line_q.push_back(CHAR_COMMA);
          1: line_q.push_back(CHAR_CR);
          2: line_q.push_back(CHAR_LF);
          3: begin
            line_q.push_back(CHAR_QUOTE);
            line_q.push_back(CHAR_QUOTE);
          end
          default: line_q.push_back(text_char());
        endcase
      end
      line_q.push_back(CHAR_QUOTE);
    end
  endtask

  task automatic build_line();
    int nf;
    int len;
    line_q.delete();
    if ($urandom_range(0, 99) < 12) begin
      // noise, biased toward the special bytes
      len = $urandom_range(1, 12);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(0, 9))
          5: line_q.push_back(CHAR_COMMA);
          6: line_q.push_back(CHAR_QUOTE);
          7: line_q.push_back(CHAR_CR);
          8: line_q.push_back(CHAR_LF);
          9: line_q.push_back(CHAR_NUL);
          default: line_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      nf = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 5);
      for (int f = 0; f < nf; f++) begin
        add_field();
        if (f < nf - 1) begin
          case ($urandom_range(0, 9))
            0: line_q.push_back(CHAR_CR);
            1: line_q.push_back(CHAR_LF);
            2: begin
              line_q.push_back(CHAR_CR);
              line_q.push_back(CHAR_LF);
            end
            default: line_q.push_back(CHAR_COMMA);
          endcase
        end
      end
      case ($urandom_range(0, 9))
        0: begin
          line_q.push_back(CHAR_CR);
          line_q.push_back(CHAR_LF);
        end
        1: line_q.push_back(CHAR_LF);
        2: line_q.push_back(CHAR_COMMA);
        3: begin
          // terminator with trailing bytes that must be ignored
          line_q.push_back(CHAR_NUL);
          len = $urandom_range(0, 3);
          for (int j = 0; j < len; j++) line_q.push_back(8'($urandom_range(0, 255)));
        end
        4: begin
          // quote left open at the end of the line
          line_q.push_back(CHAR_COMMA);
          line_q.push_back(CHAR_QUOTE);
          line_q.push_back(text_char());
        end
        default: ;
      endcase
      if (line_q.size() == 0) line_q.push_back(text_char());
    end
  endtask

  task automatic run_lines(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      build_line();
      foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1, 1'b0, '0);
      sent += line_q.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // typed rows start from reset state with capacity 17
    row_typed("x",        1'b0, "x",   1'b1, 1'b0, 8'd0, 1'b0, 8'd0);
    row_typed(8'hFF,      1'b0, 8'hFF, 1'b1, 1'b0, 8'd0, 1'b0, 8'd0);
    row_typed(CHAR_NUL,   1'b1, 8'h00, 1'b0, 1'b1, 8'd0, 1'b1, 8'd1);  // terminator closes
    row_typed(CHAR_NUL,   1'b1, 8'h00, 1'b0, 1'b0, 8'd0, 1'b1, 8'd0);  // empty line
    row_typed(CHAR_COMMA, 1'b1, 8'h00, 1'b0, 1'b1, 8'd0, 1'b1, 8'd1);  // lone comma
    // quoted field with a doubled quote, then a comma after the closing quote
    row(CHAR_QUOTE, 1'b0);
    row("a",        1'b0);
    row(CHAR_QUOTE, 1'b0);
    row(CHAR_QUOTE, 1'b0);
    row(CHAR_QUOTE, 1'b0);
    row(CHAR_COMMA, 1'b0);
    // quote still pending when the line ends
    row(CHAR_QUOTE, 1'b0);
    row(CHAR_QUOTE, 1'b1);
    // break, skipped break, then a quoted field left by a plain byte
    row("b",        1'b0);
    row(CHAR_CR,    1'b0);
    row(CHAR_LF,    1'b0);
    row(CHAR_QUOTE, 1'b0);
    row("c",        1'b0);
    row(CHAR_QUOTE, 1'b0);
    row("d",        1'b0);
    row(CHAR_COMMA, 1'b1);   // comma just before the end opens nothing
    // quote inside an unquoted field, line ended by a break
    row("e",        1'b0);
    row(CHAR_QUOTE, 1'b0);
    row(CHAR_LF,    1'b1);
    // bytes after a terminator are ignored
    row("g",        1'b0);
    row(CHAR_NUL,   1'b0);
    row("h",        1'b1);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].eol, dir_tab[i].typed,
                                   dir_tab[i].want);
    run_lines(235);

    // smallest capacity, with the receiver holding off while bytes keep coming
    set_capacity(8'd1);
    hold_req   = 1'b1;
    burst_left = 400;
    run_lines(235);

    // largest capacity: one line of empty fields runs past it
    set_capacity(8'd255);
    for (int i = 0; i < 258; i++) send_byte(CHAR_COMMA, i == 257, 1'b0, '0);
    run_lines(235);

    set_capacity(8'd2);
    run_lines(235);

    set_capacity(8'($urandom_range(1, 255)));
    hold_req   = 1'b1;
    burst_left = 400;
    run_lines(235);

    set_capacity(8'd4);
    run_lines(235);

    set_capacity(8'($urandom_range(5, 30)));
    run_lines(235);

    drain();
    repeat (8) @(posedge clk_i);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
